FILE: sv/slab_slot_allocator_top_macros.svh
// Assertion macros for the slab slot allocator checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef SLAB_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SSA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slab allocator check failed");

// next-cycle implication, disabled in reset
`define SSA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slab allocator check failed");

`endif

FILE: sv/ssa_pkg.sv
// Shared constants, codes and types of the slab slot allocator.
// No dependencies.
package ssa_pkg;

	localparam int NUM_SLABS = 16;
	localparam int MAX_SLOTS = 64;
	localparam int CHUNK     = 16;

	localparam int SLAB_W = $clog2(NUM_SLABS);
	localparam int LINK_W = $clog2(NUM_SLABS + 1);
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int CHUNK_LIM = (CHUNK < 32) ? CHUNK : 32;
	localparam int CC_W   = $clog2(CHUNK_LIM + 1);

	localparam int SLOT_SIZE_W  = 15;
	localparam int SLOTS_W      = 7;
	localparam int SLAB_BYTES_W = 17;
	localparam int ADDR_W       = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int PROD_W       = SLAB_W + SLAB_BYTES_W;
	localparam int SPROD_W      = SLOT_W + SLOT_SIZE_W;

	// divider: offset inside a slab over slot size
	localparam int DIVD_W = SLAB_BYTES_W;
	localparam int DIVS_W = SLOT_SIZE_W;
	localparam int DCNT_W = $clog2(DIVD_W);

	localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLABS);

	typedef logic [1:0] list_t;
	localparam list_t L_EMPTY = 2'd0;
	localparam list_t L_PART  = 2'd1;
	localparam list_t L_FULL  = 2'd2;

	typedef logic [1:0] tag_t;
	localparam tag_t TAG_POOL  = 2'd0;
	localparam tag_t TAG_EMPTY = 2'd1;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_SHRINK = 2'd2;

	localparam logic [1:0] RK_CONSTRUCT = 2'd0;
	localparam logic [1:0] RK_ALLOC     = 2'd1;
	localparam logic [1:0] RK_FREE      = 2'd2;
	localparam logic [1:0] RK_SHRINK    = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SLAB   = 2'd1;
	localparam logic [1:0] ST_NOT_OWNED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BYTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_CTOR   = 3'd4;

	typedef struct packed {
		logic [1:0]        rk;
		logic [1:0]        status;
		logic [ADDR_W-1:0] addr;
		logic [3:0]        slab;
		logic [5:0]        slot;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [MAX_SLOTS-1:0] free_map;
		logic [MAX_SLOTS-1:0] built_map;
		logic [CNT_W-1:0]     used;
	} rec_t;

endpackage

FILE: sv/ssa_if.sv
// Request and result channel interfaces of the slab slot allocator.
// Depends on ssa_pkg.
interface ssa_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic [ssa_pkg::ADDR_W-1:0] obj_address;

	modport source (output valid, output kind, output obj_address, input ready);
	modport sink (input valid, input kind, input obj_address, output ready);
endinterface

interface ssa_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                result_kind;
	logic [1:0]                status;
	logic [ssa_pkg::ADDR_W-1:0] out_address;
	logic [3:0]                slab_number;
	logic [5:0]                slot_number;
	logic                      last;

	modport source (output valid, output result_kind, output status, output out_address,
		output slab_number, output slot_number, output last, input ready);
	modport sink (input valid, input result_kind, input status, input out_address,
		input slab_number, input slot_number, input last, output ready);
endinterface

FILE: sv/slab_slot_allocator_top.sv
// Slab slot allocator: one object cache over a fixed pool of 16 slab records.
// Depends on ssa_pkg, ssa_if and ssa_div.
//
// Requests are taken one at a time. The slab bitmaps and use counts live in one
// record memory with a registered read. Alloc scans the partial slabs in
// constructor mode, emits at most 16 construct requests and relinks the slab
// when it changes list. Free checks the range of one slab after another; the
// slot index comes from a bit-serial divider. A result waits in an output
// register; a new request is taken once the previous one has placed its last
// result there. Slab records need no clearing at reset.
module slab_slot_allocator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	ssa_req_if.sink                          req,
	ssa_rsp_if.source                        rsp,
	input  logic                             cfg_we,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_A_WALK = 13'b0000000000010,
		S_A_LOAD = 13'b0000000000100,
		S_A_CHK  = 13'b0000000001000,
		S_A_CTOR = 13'b0000000010000,
		S_A_PICK = 13'b0000000100000,
		S_MV_UN  = 13'b0000001000000,
		S_MV_PU  = 13'b0000010000000,
		S_F_WALK = 13'b0000100000000,
		S_F_DIV  = 13'b0001000000000,
		S_F_LOAD = 13'b0010000000000,
		S_F_UPD  = 13'b0100000000000,
		S_ONE    = 13'b1000000000000
	} state_t;

	localparam int SW = ssa_pkg::SLAB_W;
	localparam int LW = ssa_pkg::LINK_W;
	localparam int MS = ssa_pkg::MAX_SLOTS;

	function automatic logic [ssa_pkg::SLOT_W-1:0] low_idx(input logic [MS-1:0] v);
		logic [ssa_pkg::SLOT_W-1:0] r;
		r = '0;
		for (int i = MS - 1; i >= 0; i--) begin
			if (v[i]) r = ssa_pkg::SLOT_W'(i);
		end
		return r;
	endfunction

	// configuration
	logic [ssa_pkg::SLOT_SIZE_W-1:0]  slot_size_q;
	logic [ssa_pkg::SLOTS_W-1:0]      slots_q;
	logic [ssa_pkg::SLAB_BYTES_W-1:0] slab_bytes_q;
	logic [ssa_pkg::ADDR_W-1:0]       base_q;
	logic                             ctor_q;

	// list state
	ssa_pkg::tag_t  tag_q  [ssa_pkg::NUM_SLABS];
	logic [LW-1:0]  nxt_q  [ssa_pkg::NUM_SLABS];
	logic [LW-1:0]  prv_q  [ssa_pkg::NUM_SLABS];
	logic [LW-1:0]  heads_q [3];

	// record memory
	logic [$bits(ssa_pkg::rec_t)-1:0] rec_mem [ssa_pkg::NUM_SLABS];
	ssa_pkg::rec_t rec_rd_q;
	logic          rd_en, we;
	logic [SW-1:0] rd_addr;
	ssa_pkg::rec_t wr_data;

	// sequencer
	state_t st_q, st_d, ret_q, ret_d;
	logic                         ov_q, ov_d;
	ssa_pkg::rsp_t                rsp_q, rsp_d, em, pend_q, pend_d;
	logic                         emit;
	logic [SW-1:0]                s_q, s_d;
	logic [LW-1:0]                t_q, t_d;
	ssa_pkg::list_t               l_q, l_d, src_q, src_d, dst_q, dst_d;
	logic [MS-1:0]                fr_q, fr_d, bt_q, bt_d, cm_q, cm_d;
	logic [ssa_pkg::CNT_W-1:0]    used_q, used_d;
	logic [ssa_pkg::CC_W-1:0]     cc_q, cc_d;
	logic [ssa_pkg::SLOT_W-1:0]   slot_q, slot_d;
	logic [ssa_pkg::ADDR_W-1:0]   obj_q, obj_d, sb_q;

	// derived
	logic                          acc, out_free;
	logic [ssa_pkg::CNT_W-1:0]     nsl;
	logic [ssa_pkg::SLOT_SIZE_W-1:0] sz;
	logic [MS-1:0]                 mask, cand;
	logic [SW-1:0]                 lk_addr, pool_idx;
	logic                          pool_any;
	logic [LW-1:0]                 nxt_rd, prv_rd;
	logic [ssa_pkg::PROD_W-1:0]    prod_s, prod_t;
	logic [ssa_pkg::ADDR_W-1:0]    off_full, slot_addr;
	logic                          hit;
	logic [ssa_pkg::SLOT_W-1:0]    ai;
	logic [ssa_pkg::SPROD_W-1:0]   sprod;
	logic                          div_start, div_done;
	logic [ssa_pkg::DIVD_W-1:0]    quo;

	assign acc       = req.valid && req.ready;
	assign req.ready = (st_q == S_IDLE);
	assign out_free  = !ov_q || rsp.ready;

	always_comb begin
		if (slots_q == '0) nsl = ssa_pkg::CNT_W'(1);
		else if (slots_q > ssa_pkg::SLOTS_W'(MS)) nsl = ssa_pkg::CNT_W'(MS);
		else nsl = ssa_pkg::CNT_W'(slots_q);
	end
	assign sz = (slot_size_q == '0) ? ssa_pkg::SLOT_SIZE_W'(1) : slot_size_q;

	always_comb begin
		for (int i = 0; i < MS; i++) mask[i] = ssa_pkg::CNT_W'(i) < nsl;
	end

	always_comb begin
		pool_any = 1'b0;
		pool_idx = '0;
		for (int i = ssa_pkg::NUM_SLABS - 1; i >= 0; i--) begin
			if (tag_q[i] == ssa_pkg::TAG_POOL) begin
				pool_any = 1'b1;
				pool_idx = SW'(i);
			end
		end
	end

	assign lk_addr = (st_q == S_A_WALK || st_q == S_F_WALK) ? t_q[SW-1:0] : s_q;
	assign nxt_rd  = nxt_q[lk_addr];
	assign prv_rd  = prv_q[lk_addr];

	// address range test for the slab under the free walk
	assign prod_t   = ssa_pkg::PROD_W'(t_q[SW-1:0]) * ssa_pkg::PROD_W'(slab_bytes_q);
	assign off_full = obj_q - (base_q + ssa_pkg::ADDR_W'(prod_t));
	assign hit      = off_full < ssa_pkg::ADDR_W'(slab_bytes_q);

	assign prod_s = ssa_pkg::PROD_W'(s_q) * ssa_pkg::PROD_W'(slab_bytes_q);
	always_ff @(posedge clk) begin
		sb_q <= base_q + ssa_pkg::ADDR_W'(prod_s);
	end

	assign cand = fr_q & (ctor_q ? bt_q : '1) & mask;
	always_comb begin
		unique case (st_q)
			S_A_CTOR: ai = low_idx(cm_q);
			S_A_PICK: ai = low_idx(cand);
			default:  ai = slot_q;
		endcase
	end
	assign sprod     = ssa_pkg::SPROD_W'(ai) * ssa_pkg::SPROD_W'(sz);
	assign slot_addr = sb_q + ssa_pkg::ADDR_W'(sprod);

	ssa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (off_full[ssa_pkg::DIVD_W-1:0]),
		.divisor  (sz),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		logic [MS-1:0]             oh;
		logic [ssa_pkg::CNT_W:0]   nu;
		logic [ssa_pkg::CNT_W-1:0] nd;
		st_d = st_q; ret_d = ret_q; pend_d = pend_q;
		s_d = s_q; t_d = t_q; l_d = l_q; src_d = src_q; dst_d = dst_q;
		fr_d = fr_q; bt_d = bt_q; cm_d = cm_q; used_d = used_q; cc_d = cc_q;
		slot_d = slot_q; obj_d = obj_q;
		emit = 1'b0; em = '0;
		rd_en = 1'b0; rd_addr = s_q; we = 1'b0;
		wr_data = '{free_map: fr_q, built_map: bt_q, used: used_q};
		div_start = 1'b0;
		oh = MS'(1) << ai;
		nu = '0;
		nd = '0;
		unique case (st_q)
			S_IDLE: begin
				if (acc) begin
					obj_d = req.obj_address;
					unique case (req.kind)
						ssa_pkg::KIND_ALLOC: begin
							if (heads_q[ssa_pkg::L_PART] == ssa_pkg::NIL) begin
								if (heads_q[ssa_pkg::L_EMPTY] != ssa_pkg::NIL) begin
									s_d   = heads_q[ssa_pkg::L_EMPTY][SW-1:0];
									src_d = ssa_pkg::L_EMPTY;
									dst_d = ssa_pkg::L_PART;
									ret_d = S_A_LOAD;
									st_d  = S_MV_UN;
								end else if (pool_any) begin
									s_d    = pool_idx;
									fr_d   = mask;
									bt_d   = '0;
									used_d = '0;
									dst_d  = ssa_pkg::L_PART;
									ret_d  = S_A_CHK;
									st_d   = S_MV_PU;
								end else begin
									pend_d = '{ssa_pkg::RK_ALLOC, ssa_pkg::ST_NO_SLAB,
										'0, '0, '0, 1'b1};
									st_d = S_ONE;
								end
							end else begin
								s_d     = heads_q[ssa_pkg::L_PART][SW-1:0];
								t_d     = heads_q[ssa_pkg::L_PART];
								rd_en   = 1'b1;
								rd_addr = heads_q[ssa_pkg::L_PART][SW-1:0];
								st_d    = ctor_q ? S_A_WALK : S_A_LOAD;
							end
						end
						ssa_pkg::KIND_FREE: begin
							t_d  = heads_q[ssa_pkg::L_PART];
							l_d  = ssa_pkg::L_PART;
							st_d = S_F_WALK;
						end
						ssa_pkg::KIND_SHRINK: begin
							pend_d = '{ssa_pkg::RK_SHRINK, ssa_pkg::ST_OK, '0, '0, '0, 1'b1};
							st_d = S_ONE;
						end
						default: ;
					endcase
				end
			end
			S_A_WALK: begin
				// first partial slab with a constructed free slot, else the head
				if (|(rec_rd_q.free_map & rec_rd_q.built_map & mask)) begin
					s_d    = t_q[SW-1:0];
					fr_d   = rec_rd_q.free_map;
					bt_d   = rec_rd_q.built_map;
					used_d = rec_rd_q.used;
					st_d   = S_A_CHK;
				end else if (nxt_rd == ssa_pkg::NIL) begin
					rd_en = 1'b1;
					st_d  = S_A_LOAD;
				end else begin
					t_d     = nxt_rd;
					rd_en   = 1'b1;
					rd_addr = nxt_rd[SW-1:0];
				end
			end
			S_A_LOAD: begin
				fr_d   = rec_rd_q.free_map;
				bt_d   = rec_rd_q.built_map;
				used_d = rec_rd_q.used;
				st_d   = S_A_CHK;
			end
			S_A_CHK: begin
				if (ctor_q && !(|(fr_q & bt_q & mask))) begin
					cm_d = fr_q & ~bt_q & mask;
					cc_d = '0;
					st_d = S_A_CTOR;
				end else begin
					st_d = S_A_PICK;
				end
			end
			S_A_CTOR: begin
				if (cm_q == '0 || cc_q == ssa_pkg::CC_W'(ssa_pkg::CHUNK_LIM)) begin
					st_d = S_A_PICK;
				end else if (out_free) begin
					emit = 1'b1;
					em   = '{ssa_pkg::RK_CONSTRUCT, ssa_pkg::ST_OK, slot_addr,
						4'(s_q), 6'(ai), 1'b0};
					bt_d = bt_q | oh;
					cm_d = cm_q & ~oh;
					cc_d = cc_q + 1'b1;
				end
			end
			S_A_PICK: begin
				if (out_free) begin
					emit  = 1'b1;
					we    = 1'b1;
					src_d = ssa_pkg::L_PART;
					dst_d = ssa_pkg::L_FULL;
					ret_d = S_IDLE;
					if (cand == '0) begin
						em   = '{ssa_pkg::RK_ALLOC, ssa_pkg::ST_NO_SLAB, '0, '0, '0, 1'b1};
						st_d = S_MV_UN;
					end else begin
						nu = {1'b0, used_q} + 1'b1;
						wr_data = '{free_map: fr_q & ~oh, built_map: bt_q,
							used: nu[ssa_pkg::CNT_W-1:0]};
						em = '{ssa_pkg::RK_ALLOC, ssa_pkg::ST_OK, slot_addr,
							4'(s_q), 6'(ai), 1'b1};
						st_d = (nu >= {1'b0, nsl}) ? S_MV_UN : S_IDLE;
					end
				end
			end
			S_MV_UN: st_d = S_MV_PU;
			S_MV_PU: begin
				st_d = ret_q;
				if (ret_q == S_A_LOAD) rd_en = 1'b1;
			end
			S_F_WALK: begin
				if (t_q == ssa_pkg::NIL) begin
					if (l_q == ssa_pkg::L_PART) begin
						l_d = ssa_pkg::L_FULL;
						t_d = heads_q[ssa_pkg::L_FULL];
					end else begin
						pend_d = '{ssa_pkg::RK_FREE, ssa_pkg::ST_NOT_OWNED,
							'0, '0, '0, 1'b1};
						st_d = S_ONE;
					end
				end else if (hit) begin
					s_d       = t_q[SW-1:0];
					div_start = 1'b1;
					st_d      = S_F_DIV;
				end else begin
					t_d = nxt_rd;
				end
			end
			S_F_DIV: begin
				if (div_done) begin
					if (quo >= ssa_pkg::DIVD_W'(nsl)) begin
						pend_d = '{ssa_pkg::RK_FREE, ssa_pkg::ST_NOT_OWNED,
							'0, '0, '0, 1'b1};
						st_d = S_ONE;
					end else begin
						slot_d = quo[ssa_pkg::SLOT_W-1:0];
						rd_en  = 1'b1;
						st_d   = S_F_LOAD;
					end
				end
			end
			S_F_LOAD: begin
				fr_d   = rec_rd_q.free_map;
				bt_d   = rec_rd_q.built_map;
				used_d = rec_rd_q.used;
				st_d   = S_F_UPD;
			end
			S_F_UPD: begin
				if (out_free) begin
					emit  = 1'b1;
					em    = '{ssa_pkg::RK_FREE, ssa_pkg::ST_OK, slot_addr,
						4'(s_q), 6'(slot_q), 1'b1};
					ret_d = S_IDLE;
					st_d  = S_IDLE;
					// a slot already free changes nothing
					if (!fr_q[slot_q]) begin
						nd = (used_q != '0) ? used_q - 1'b1 : used_q;
						we = 1'b1;
						wr_data = '{free_map: fr_q | oh, built_map: bt_q, used: nd};
						src_d = l_q;
						if (nd == '0) begin
							dst_d = ssa_pkg::L_EMPTY;
							st_d  = S_MV_UN;
						end else if (l_q == ssa_pkg::L_FULL) begin
							dst_d = ssa_pkg::L_PART;
							st_d  = S_MV_UN;
						end
					end
				end
			end
			S_ONE: begin
				if (out_free) begin
					emit = 1'b1;
					em   = pend_q;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
		ov_d  = emit ? 1'b1 : (rsp.ready ? 1'b0 : ov_q);
		rsp_d = emit ? em : rsp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			ret_q <= S_IDLE;
			ov_q  <= 1'b0;
		end else begin
			st_q  <= st_d;
			ret_q <= ret_d;
			ov_q  <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q  <= rsp_d;
		pend_q <= pend_d;
		s_q    <= s_d;
		t_q    <= t_d;
		l_q    <= l_d;
		src_q  <= src_d;
		dst_q  <= dst_d;
		fr_q   <= fr_d;
		bt_q   <= bt_d;
		cm_q   <= cm_d;
		used_q <= used_d;
		cc_q   <= cc_d;
		slot_q <= slot_d;
		obj_q  <= obj_d;
	end

	// a write-back always completes before the next read of any record is issued
	always_ff @(posedge clk) begin
		if (we) rec_mem[s_q] <= wr_data;
		if (rd_en) rec_rd_q <= ssa_pkg::rec_t'(rec_mem[rd_addr]);
	end

	// doubly linked lists; order matches push-at-head, unlink-anywhere
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssa_pkg::NUM_SLABS; i++) begin
				tag_q[i] <= ssa_pkg::TAG_POOL;
				nxt_q[i] <= ssa_pkg::NIL;
				prv_q[i] <= ssa_pkg::NIL;
			end
			for (int i = 0; i < 3; i++) heads_q[i] <= ssa_pkg::NIL;
		end else begin
			if (st_q == S_IDLE && acc && req.kind == ssa_pkg::KIND_SHRINK) begin
				for (int i = 0; i < ssa_pkg::NUM_SLABS; i++) begin
					if (tag_q[i] == ssa_pkg::TAG_EMPTY) begin
						tag_q[i] <= ssa_pkg::TAG_POOL;
						nxt_q[i] <= ssa_pkg::NIL;
						prv_q[i] <= ssa_pkg::NIL;
					end
				end
				heads_q[ssa_pkg::L_EMPTY] <= ssa_pkg::NIL;
			end
			if (st_q == S_MV_UN) begin
				if (prv_rd == ssa_pkg::NIL) heads_q[src_q] <= nxt_rd;
				else nxt_q[prv_rd[SW-1:0]] <= nxt_rd;
				if (nxt_rd != ssa_pkg::NIL) prv_q[nxt_rd[SW-1:0]] <= prv_rd;
			end
			if (st_q == S_MV_PU) begin
				nxt_q[s_q] <= heads_q[dst_q];
				prv_q[s_q] <= ssa_pkg::NIL;
				if (heads_q[dst_q] != ssa_pkg::NIL) prv_q[heads_q[dst_q][SW-1:0]] <= LW'(s_q);
				heads_q[dst_q] <= LW'(s_q);
				tag_q[s_q] <= dst_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_size_q  <= ssa_pkg::SLOT_SIZE_W'(64);
			slots_q      <= ssa_pkg::SLOTS_W'(64);
			slab_bytes_q <= ssa_pkg::SLAB_BYTES_W'(4096);
			base_q       <= '0;
			ctor_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssa_pkg::CFG_SLOT_SIZE:  slot_size_q  <= cfg_data[ssa_pkg::SLOT_SIZE_W-1:0];
				ssa_pkg::CFG_SLOTS:      slots_q      <= cfg_data[ssa_pkg::SLOTS_W-1:0];
				ssa_pkg::CFG_SLAB_BYTES: slab_bytes_q <= cfg_data[ssa_pkg::SLAB_BYTES_W-1:0];
				ssa_pkg::CFG_BASE:       base_q       <= cfg_data[ssa_pkg::ADDR_W-1:0];
				ssa_pkg::CFG_HAS_CTOR:   ctor_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.result_kind = rsp_q.rk;
	assign rsp.status      = rsp_q.status;
	assign rsp.out_address = rsp_q.addr;
	assign rsp.slab_number = rsp_q.slab;
	assign rsp.slot_number = rsp_q.slot;
	assign rsp.last        = rsp_q.last;
endmodule

FILE: sv/ssa_div.sv
// Restoring divider, one quotient bit per cycle: slab offset over slot size.
// Depends on ssa_pkg.
module ssa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ssa_pkg::DIVD_W-1:0]  dividend,
	input  logic [ssa_pkg::DIVS_W-1:0]  divisor,
	output logic                        done,
	output logic [ssa_pkg::DIVD_W-1:0]  quotient
);
	logic                       run_q;
	logic                       done_q;
	logic [ssa_pkg::DCNT_W-1:0] cnt_q;
	logic [ssa_pkg::DIVS_W-1:0] rem_q;
	logic [ssa_pkg::DIVD_W-1:0] quo_q;
	logic [ssa_pkg::DIVS_W-1:0] div_q;
	logic [ssa_pkg::DIVS_W:0]   trial;
	logic                       ge;

	assign trial = {rem_q, quo_q[ssa_pkg::DIVD_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= ssa_pkg::DCNT_W'(ssa_pkg::DIVD_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? ssa_pkg::DIVS_W'(trial - {1'b0, div_q})
				: trial[ssa_pkg::DIVS_W-1:0];
			quo_q <= {quo_q[ssa_pkg::DIVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

FILE: sv/ssa_checker.sv
// Port-level checks of the slab slot allocator result channel, bound to the top.
// Depends on ssa_pkg and slab_slot_allocator_top_macros.svh.
`include "slab_slot_allocator_top_macros.svh"

module ssa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [1:0]                   result_kind,
	input logic [1:0]                   status,
	input logic [ssa_pkg::ADDR_W-1:0]   out_address,
	input logic                         last
);
	`SSA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_address) && $stable(result_kind))
	`SSA_ASSERT_IMP(a_ctor_not_last, rsp_valid && result_kind == ssa_pkg::RK_CONSTRUCT, !last && status == ssa_pkg::ST_OK)
	`SSA_ASSERT_IMP(a_done_is_last, rsp_valid && result_kind != ssa_pkg::RK_CONSTRUCT, last)
	`SSA_ASSERT_IMP(a_err_no_addr, rsp_valid && status != ssa_pkg::ST_OK, out_address == '0)
endmodule

bind slab_slot_allocator_top ssa_checker u_ssa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.result_kind (rsp.result_kind),
	.status      (rsp.status),
	.out_address (rsp.out_address),
	.last        (rsp.last)
);
